// ----- rtl/gesr_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// graph edge store reachability unit. No dependencies.
package gesr_pkg;

   localparam int NODE_COUNT    = 64;
   localparam int EDGE_CAPACITY = 256;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int EDGE_W        = $clog2(EDGE_CAPACITY);
   localparam int LINK_W        = $clog2(EDGE_CAPACITY + 1);
   localparam int SP_W          = $clog2(NODE_COUNT + 1);

   // end-of-list marker in head pointers and next links
   localparam logic [LINK_W-1:0] LIST_END = LINK_W'(EDGE_CAPACITY);

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic       capture;          // latch source/target of an accepted transfer
      logic       head_from_stack;  // head read address from popped node, else source
      logic       edge_rd_del;      // edge read address is the newest edge
      logic       link_from_head;   // current link from head read, else next link
      logic       add_write;
      logic       del_write;
      logic       q_init;
      logic       pop;
      logic       visit;
      logic       rsp_load;
      logic       rsp_reach;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic sp_zero;
      logic link_ok;
      logic hit;
   } sts_type;

endpackage

// ----- rtl/gesr_datapath.sv -----
// Datapath: head pointer, edge and walk stack memories, visited flags,
// counters and the result register. Depends on gesr_pkg.
module gesr_datapath import gesr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [NODE_W-1:0] req_source,
   input  logic [NODE_W-1:0] req_target,
   output sts_type           sts,
   output logic              rsp_reachable,
   output logic [1:0]        rsp_status,
   output logic [LINK_W-1:0] rsp_edges
);

   logic [NODE_W-1:0] src_ff, dst_ff;
   logic [LINK_W-1:0] count_ff, count_in;
   logic [SP_W-1:0]   sp_ff, sp_in;

   logic [LINK_W-1:0]     head_mem [NODE_COUNT];
   logic [NODE_COUNT-1:0] head_vld_ff, head_vld_in;
   logic [LINK_W-1:0]     head_rd_ff;
   logic                  head_vld_rd_ff;

   logic [NODE_W-1:0] edge_tgt_mem  [EDGE_CAPACITY];
   logic [NODE_W-1:0] edge_src_mem  [EDGE_CAPACITY];
   logic [LINK_W-1:0] edge_next_mem [EDGE_CAPACITY];
   logic [NODE_W-1:0] edge_tgt_rd_ff, edge_src_rd_ff;
   logic [LINK_W-1:0] edge_next_rd_ff;

   logic [NODE_W-1:0]     stack_mem [NODE_COUNT];
   logic [NODE_W-1:0]     stack_rd_ff;
   logic [NODE_COUNT-1:0] visited_ff, visited_in;

   logic              rsp_reach_ff;
   logic [1:0]        rsp_status_ff;
   logic [LINK_W-1:0] rsp_edges_ff;

   logic [LINK_W-1:0] head_link, link_cur, count_dec, head_wd;
   logic [EDGE_W-1:0] edge_rd_addr;
   logic [NODE_W-1:0] head_rd_addr, head_wa, stack_wa, stack_wd;
   logic [SP_W-1:0]   sp_dec;
   logic              hit, push, head_we, stack_we;

   always_comb begin
      head_link    = head_vld_rd_ff ? head_rd_ff : LIST_END;
      link_cur     = cmd.link_from_head ? head_link : edge_next_rd_ff;
      count_dec    = count_ff - LINK_W'(1);
      edge_rd_addr = cmd.edge_rd_del ? count_dec[EDGE_W-1:0] : link_cur[EDGE_W-1:0];
      head_rd_addr = cmd.head_from_stack ? stack_rd_ff : src_ff;
      sp_dec       = sp_ff - SP_W'(1);
      hit          = (edge_tgt_rd_ff == dst_ff);
      push         = cmd.visit & ~hit & ~visited_ff[edge_tgt_rd_ff]
                     & (sp_ff < SP_W'(NODE_COUNT));

      head_we = cmd.add_write | cmd.del_write;
      head_wa = cmd.add_write ? src_ff : edge_src_rd_ff;
      head_wd = cmd.add_write ? count_ff : edge_next_rd_ff;

      stack_we = cmd.q_init | push;
      stack_wa = cmd.q_init ? '0 : sp_ff[NODE_W-1:0];
      stack_wd = cmd.q_init ? src_ff : edge_tgt_rd_ff;

      head_vld_in = head_vld_ff;
      if (head_we) begin
         head_vld_in[head_wa] = 1'b1;
      end

      count_in = count_ff;
      if (cmd.add_write) begin
         count_in = count_ff + LINK_W'(1);
      end else if (cmd.del_write) begin
         count_in = count_dec;
      end

      sp_in = sp_ff;
      if (cmd.q_init) begin
         sp_in = SP_W'(1);
      end else if (cmd.pop) begin
         sp_in = sp_dec;
      end else if (push) begin
         sp_in = sp_ff + SP_W'(1);
      end

      visited_in = visited_ff;
      if (cmd.q_init) begin
         visited_in = '0;
         visited_in[src_ff] = 1'b1;
      end else if (push) begin
         visited_in[edge_tgt_rd_ff] = 1'b1;
      end

      sts.full    = (count_ff >= LINK_W'(EDGE_CAPACITY));
      sts.empty   = (count_ff == '0);
      sts.sp_zero = (sp_ff == '0);
      sts.link_ok = (link_cur < count_ff);
      sts.hit     = hit;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         sp_ff       <= '0;
         head_vld_ff <= '0;
      end else begin
         count_ff    <= count_in;
         sp_ff       <= sp_in;
         head_vld_ff <= head_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_ff <= req_source;
         dst_ff <= req_target;
      end
      visited_ff <= visited_in;
      if (cmd.rsp_load) begin
         rsp_reach_ff  <= cmd.rsp_reach;
         rsp_status_ff <= cmd.rsp_status;
         rsp_edges_ff  <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_rd_ff     <= head_mem[head_rd_addr];
      head_vld_rd_ff <= head_vld_ff[head_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         edge_tgt_mem[count_ff[EDGE_W-1:0]]  <= dst_ff;
         edge_src_mem[count_ff[EDGE_W-1:0]]  <= src_ff;
         edge_next_mem[count_ff[EDGE_W-1:0]] <= head_link;
      end
      edge_tgt_rd_ff  <= edge_tgt_mem[edge_rd_addr];
      edge_src_rd_ff  <= edge_src_mem[edge_rd_addr];
      edge_next_rd_ff <= edge_next_mem[edge_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      stack_rd_ff <= stack_mem[sp_dec[NODE_W-1:0]];
   end

   assign rsp_reachable = rsp_reach_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_edges     = rsp_edges_ff;

endmodule

// ----- rtl/gesr_ctrl.sv -----
// Controller state machine: sequences add, delete and the depth-first walk,
// owns the request/result handshake. Depends on gesr_pkg.
module gesr_ctrl import gesr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_op,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_ADD_RD = 11'b000_0000_0010,
      S_ADD_WR = 11'b000_0000_0100,
      S_DEL_RD = 11'b000_0000_1000,
      S_DEL_WR = 11'b000_0001_0000,
      S_Q_INIT = 11'b000_0010_0000,
      S_Q_POP  = 11'b000_0100_0000,
      S_Q_HEAD = 11'b000_1000_0000,
      S_Q_LINK = 11'b001_0000_0000,
      S_Q_EDGE = 11'b010_0000_0000,
      S_FINISH = 11'b100_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       reach_ff, reach_in;
   status_type status_ff, status_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      reach_in     = reach_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               reach_in    = 1'b0;
               status_in   = STATUS_DONE;
               unique case (op_type'(req_op))
                  OP_ADD: begin
                     if (sts.full) begin
                        status_in = STATUS_FULL;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_ADD_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (sts.empty) begin
                        status_in = STATUS_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_DEL_RD;
                     end
                  end
                  OP_QUERY: state_in = S_Q_INIT;
                  default:  state_in = S_FINISH;
               endcase
            end
         end
         S_ADD_RD: state_in = S_ADD_WR;
         S_ADD_WR: begin
            cmd.add_write = 1'b1;
            state_in      = S_FINISH;
         end
         S_DEL_RD: begin
            cmd.edge_rd_del = 1'b1;
            state_in        = S_DEL_WR;
         end
         S_DEL_WR: begin
            cmd.del_write = 1'b1;
            state_in      = S_FINISH;
         end
         S_Q_INIT: begin
            cmd.q_init = 1'b1;
            state_in   = S_Q_POP;
         end
         S_Q_POP: begin
            if (sts.sp_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_Q_HEAD;
            end
         end
         S_Q_HEAD: begin
            cmd.head_from_stack = 1'b1;
            state_in            = S_Q_LINK;
         end
         S_Q_LINK: begin
            cmd.link_from_head = 1'b1;
            state_in           = sts.link_ok ? S_Q_EDGE : S_Q_POP;
         end
         S_Q_EDGE: begin
            if (sts.hit) begin
               reach_in = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.visit = 1'b1;
               state_in  = sts.link_ok ? S_Q_EDGE : S_Q_POP;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      cmd.rsp_reach  = reach_ff;
      cmd.rsp_status = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reach_ff  <= reach_in;
      status_ff <= status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/graph_edge_store_reachability_unit.sv -----
// Top level of the graph edge store reachability unit: stream ports,
// controller and datapath. Depends on gesr_pkg, gesr_ctrl, gesr_datapath.
//
//   channel   direction  signals                      carries
//   req_      in         tvalid tready tdata tuser    one operation
//   rsp_      out        tvalid tready tdata          one result per operation
//
// One operation at a time; a result waits in the output register while the
// next operation is already taken. Add: ADD_RD, ADD_WR, FINISH; delete: DEL_RD,
// DEL_WR, FINISH; a refused one or an unused code goes straight to FINISH.
// Query: Q_INIT, then Q_POP, Q_HEAD, Q_LINK per node popped from the walk stack
// and Q_EDGE per edge scanned. Reset is synchronous and empties every list
// through per-node head valid bits; a stalled result holds the next in FINISH.
module graph_edge_store_reachability_unit import gesr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] source_node, [11:6] target_node, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] reachable, [2:1] status, [11:3] edges_stored
);

   cmd_type           cmd;
   sts_type           sts;
   logic              rsp_reachable;
   logic [1:0]        rsp_status;
   logic [LINK_W-1:0] rsp_edges;

   // sequence the operations; the datapath only follows commands
   gesr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // memories, walk stack, visited flags and the result register
   gesr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_source    (req_tdata[NODE_W-1:0]),
      .req_target    (req_tdata[2*NODE_W-1:NODE_W]),
      .sts           (sts),
      .rsp_reachable (rsp_reachable),
      .rsp_status    (rsp_status),
      .rsp_edges     (rsp_edges)
   );

   // pack the result fields from bit 0 up, zero fill to 16 bits
   assign rsp_tdata = {4'b0000, rsp_edges, rsp_status, rsp_reachable};

   // one operation in flight: no second transfer right behind the first
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an operation is in progress");

   // a refused add only happens on a full store
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:1] == STATUS_FULL)
      |-> rsp_tdata[11:3] == LINK_W'(EDGE_CAPACITY))
      else $error("store-full status with edge count below capacity");

   // a refused delete only happens on an empty store
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:1] == STATUS_EMPTY) |-> rsp_tdata[11:3] == '0)
      else $error("store-empty status with edges held");

   // a positive reachability answer never comes with a refusal
   a_reach_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> rsp_tdata[2:1] == STATUS_DONE)
      else $error("reachable result with a refusal status");

endmodule
